[hdl/rpc_pkg.sv]
// rpc_pkg: shared widths, payload structs and control structs for the
// relation properties and closure block. No dependencies.
`timescale 1ns / 1ps

package rpc_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int ROW_W        = 16;
	localparam int N_CAP        = (MAX_ELEMENTS < ROW_W) ? MAX_ELEMENTS : ROW_W;
	localparam int IDX_W        = 4;
	localparam int SIZE_W       = 5;
	localparam int CNT_W        = SIZE_W;

	typedef struct packed {
		logic [ROW_W-1:0] row_bits;
		logic             last_row;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [ROW_W-1:0] closure_row;
		logic             all_reflexive;
		logic             is_symmetric;
		logic             is_antisymmetric;
		logic             is_transitive;
		logic             last_result;
	} result_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic copy;
		logic pivot;
		logic check;
		logic emit;
		logic cnt_clr;
		logic cnt_inc;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic cnt_last;
	} status_t;

endpackage

[hdl/rpc_ctrl.sv]
// rpc_ctrl: sequencer for load, copy, closure pivots, transitivity check
// and row output. Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_ctrl import rpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    last_row,
	input  status_t st,
	output cmd_t    cmd,
	output logic    busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COPY  = 3'd1;
	localparam logic [2:0] S_PIVOT = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_row) state_d = S_COPY;
				end
			end
			S_COPY: begin
				cmd.copy    = 1'b1;
				cmd.cnt_clr = 1'b1;
				state_d     = S_PIVOT;
			end
			S_PIVOT: begin
				cmd.pivot = 1'b1;
				if (st.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_CHECK;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (st.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_pivot_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIVOT && st.cnt_last) |=> (state_q == S_CHECK))
		else $error("closure pass did not end after the final pivot");

	a_copy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> $past(start && last_row && state_q == S_IDLE))
		else $error("closure started without a final row word");

endmodule

[hdl/rpc_dpath.sv]
// rpc_dpath: relation and closure row registers, size register, load count,
// property flags and result register. Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_dpath import rpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              size_we,
	input  logic [SIZE_W-1:0] size_data,
	input  item_t             item,
	input  cmd_t              cmd,
	output status_t           st,
	output result_t           result,
	output logic              done
);

	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n_act;
	logic [ROW_W-1:0]  col_mask;
	logic [CNT_W-1:0]  row_cnt_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  last_idx;
	logic              done_q;
	result_t           result_q;

	logic [ROW_W-1:0]  rel_q [N_CAP];
	logic [ROW_W-1:0]  clo_q [N_CAP];
	logic [ROW_W-1:0]  mm    [N_CAP];

	logic refl_q, sym_q, anti_q, trans_q;
	logic refl_d, sym_d, anti_d, trans_d;
	logic [ROW_W-1:0] pivot_row;

	// clamp the programmed size into 1..N_CAP
	always_comb begin
		if (size_q == '0) begin
			n_act = CNT_W'(1);
		end else if (size_q > CNT_W'(N_CAP)) begin
			n_act = CNT_W'(N_CAP);
		end else begin
			n_act = size_q;
		end
	end

	always_comb begin
		for (int k = 0; k < ROW_W; k++) begin
			col_mask[k] = (CNT_W'(k) < n_act);
		end
	end

	assign last_idx    = IDX_W'(n_act - CNT_W'(1));
	assign st.cnt_last = (cnt_q == last_idx);
	assign pivot_row   = clo_q[cnt_q];

	// masked relation: rows past the fill count or the universe read as zero, and columns outside the universe are cleared
	always_comb begin
		for (int i = 0; i < N_CAP; i++) begin
			if (CNT_W'(i) < fill_q && CNT_W'(i) < n_act) begin
				mm[i] = rel_q[i] & col_mask;
			end else begin
				mm[i] = '0;
			end
		end
	end

	always_comb begin
		refl_d  = 1'b1;
		sym_d   = 1'b1;
		anti_d  = 1'b1;
		trans_d = 1'b1;
		for (int i = 0; i < N_CAP; i++) begin
			if (col_mask[i] && !mm[i][i]) refl_d = 1'b0;
			for (int j = 0; j < N_CAP; j++) begin
				if (mm[i][j] != mm[j][i]) sym_d = 1'b0;
				if (i != j && mm[i][j] && mm[j][i]) anti_d = 1'b0;
			end
			// transitive exactly when the closure adds nothing
			if (clo_q[i] != rel_q[i]) trans_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_W'(16);
			row_cnt_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (size_we) size_q <= size_data;
			if (cmd.load) begin
				if (item.last_row) begin
					row_cnt_q <= '0;
				end else if (row_cnt_q < n_act) begin
					row_cnt_q <= row_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (row_cnt_q < n_act) rel_q[row_cnt_q[IDX_W-1:0]] <= item.row_bits;
			if (item.last_row) begin
				fill_q <= (row_cnt_q < n_act) ? row_cnt_q + CNT_W'(1) : row_cnt_q;
			end
		end
		if (cmd.copy) begin
			for (int i = 0; i < N_CAP; i++) begin
				rel_q[i] <= mm[i];
				clo_q[i] <= mm[i];
			end
			refl_q <= refl_d;
			sym_q  <= sym_d;
			anti_q <= anti_d;
		end
		// one Warshall pivot: every row holding the pivot bit takes in the pivot row
		if (cmd.pivot) begin
			for (int i = 0; i < N_CAP; i++) begin
				if (clo_q[i][cnt_q]) clo_q[i] <= clo_q[i] | pivot_row;
			end
		end
		if (cmd.check) trans_q <= trans_d;
		if (cmd.emit) begin
			result_q.row_index        <= cnt_q;
			result_q.closure_row      <= pivot_row;
			result_q.all_reflexive    <= refl_q;
			result_q.is_symmetric     <= sym_q;
			result_q.is_antisymmetric <= anti_q;
			result_q.is_transitive    <= trans_q;
			result_q.last_result      <= st.cnt_last;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	a_done_follows_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.emit))
		else $error("result word without an emit step");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= CNT_W'(N_CAP))
		else $error("load row count beyond capacity");

	a_row_in_universe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((result_q.closure_row & ~col_mask) == '0))
		else $error("closure row has bits outside the universe");

endmodule

[hdl/relation_properties_and_closure.sv]
// relation_properties_and_closure: top level joining the controller and the
// datapath. Depends on rpc_pkg, rpc_ctrl and rpc_dpath.
`timescale 1ns / 1ps

// Rows of a relation are written one word per cycle with start while busy is
// low; non-final rows never raise busy. The word marked last_row starts the
// computation: busy rises for a copy step, a Warshall pivot for each element
// over the closure row registers, a transitivity check and the output of n
// result words, where n is the clamped universe size. The result words
// appear on consecutive cycles with done high; the receiver cannot stall
// them. The next start is taken during the cycle of the last result word.
module relation_properties_and_closure import rpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	input  logic              size_we,
	input  logic [SIZE_W-1:0] size_data,
	output result_t           result,
	output logic              done
);

	cmd_t    cmd;
	status_t st;

	rpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_row (item.last_row),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	rpc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.size_we   (size_we),
		.size_data (size_data),
		.item      (item),
		.cmd       (cmd),
		.st        (st),
		.result    (result),
		.done      (done)
	);

endmodule
